// ===== rtl/gea_pkg.sv =====
// Shared constants and types for the generational entity allocator.
// Holds slot geometry, operation and status codes and memory word layouts.
// No dependencies.
package gea_pkg;

   // Slot geometry
   localparam int SLOT_COUNT      = 1024;
   localparam int SLOT_BITS       = $clog2(SLOT_COUNT);
   localparam int COUNT_BITS      = $clog2(SLOT_COUNT + 1);
   localparam int COMPONENT_KINDS = 64;
   localparam int GENERATION_BITS = 16;

   // Item field widths
   localparam int FUNC_BITS   = 3;
   localparam int INDEX_BITS  = 10;
   localparam int KIND_BITS   = 6;
   localparam int STATUS_BITS = 3;

   // Operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_CREATE   = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_DESTROY  = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_VALIDATE = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_ADD      = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE   = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_TEST     = 3'd5;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_INVALID = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_HAS     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_LACKS   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

   // One word of the slot memory
   typedef struct packed {
      logic [GENERATION_BITS-1:0] generation;
      logic                       live;
      logic [COMPONENT_KINDS-1:0] components;
   } slot_word_type;

   // One entry of the free stack: slot plus the generation it will reopen with
   typedef struct packed {
      logic [GENERATION_BITS-1:0] generation;
      logic [SLOT_BITS-1:0]       slot;
   } free_word_type;

endpackage

// ===== rtl/generational_entity_allocator.sv =====
// Generational entity allocator: slot memory, free stack memory and sequencer.
// Depends on gea_pkg for geometry, codes and memory word layouts.
//
//  Port group  Dir  Meaning
//  req_*       in   one operation item (create/destroy/validate/add/remove/test)
//  rsp_*       out  one result item per operation
//
// For each item the sequencer first accepts it and reads the slot and free stack
// memories, then evaluates it, writes back and loads the result register.
// The result register lets a new item be accepted while a result waits;
// evaluation holds while that register is still occupied.
// Reset is synchronous. Slots at or above the fresh count read as zero, so
// the memories need no clearing pass.
module generational_entity_allocator
   import gea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [12:3] entity_index, [28:13] entity_generation,
   // [34:29] component_kind, [39:35] zero
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] handle_index, [25:10] handle_generation, [28:26] status,
   // [29] answer, [31:30] zero
   output logic [31:0] rsp_tdata
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   // Control state
   logic                  state_ff, state_in;
   logic [COUNT_BITS-1:0] free_count_ff, free_count_in;
   logic [COUNT_BITS-1:0] fresh_count_ff, fresh_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff;

   // Operation registers
   logic [FUNC_BITS-1:0]       func_ff;
   logic [INDEX_BITS-1:0]      index_ff;
   logic [GENERATION_BITS-1:0] gen_ff;
   logic [KIND_BITS-1:0]       kind_ff;
   logic                       seen_ff;

   // Memories
   slot_word_type slot_mem [SLOT_COUNT];
   free_word_type free_mem [SLOT_COUNT];
   slot_word_type slot_rd_ff;
   free_word_type free_rd_ff;

   logic                 accept;
   logic                 finish;
   logic [INDEX_BITS-1:0] req_index;
   logic                 slot_we;
   logic [SLOT_BITS-1:0] slot_wa;
   slot_word_type        slot_wd;
   logic                 free_we;
   free_word_type        free_wd;
   logic [COUNT_BITS-1:0] free_top;

   // Evaluation signals
   slot_word_type              cur;
   logic                       valid;
   logic                       kind_ok;
   logic                       hit;
   logic [COMPONENT_KINDS-1:0] bit_mask;
   logic [GENERATION_BITS-1:0] next_gen;
   logic [INDEX_BITS-1:0]      res_index;
   logic [GENERATION_BITS-1:0] res_gen;
   logic [STATUS_BITS-1:0]     res_status;
   logic                       res_answer;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign finish     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign req_index  = req_tdata[12:3];
   assign free_top   = free_count_ff - COUNT_BITS'(1);

   // Capture the operation and note whether its slot was ever handed out
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_tdata[2:0];
         index_ff <= req_index;
         gen_ff   <= req_tdata[28:13];
         kind_ff  <= req_tdata[34:29];
         seen_ff  <= (COUNT_BITS'(req_index) < fresh_count_ff);
      end
   end

   // Slot memory: read on accept, write when the operation finishes
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (accept) begin
         slot_rd_ff <= slot_mem[SLOT_BITS'(req_index)];
      end
   end

   // Free stack memory: read the top on accept, push on destroy
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_count_ff[SLOT_BITS-1:0]] <= free_wd;
      end
      if (accept) begin
         free_rd_ff <= free_mem[free_top[SLOT_BITS-1:0]];
      end
   end

   // Evaluate the operation against the slot read back
   always_comb begin
      cur        = seen_ff ? slot_rd_ff : '0;
      valid      = (32'(index_ff) < SLOT_COUNT) && cur.live && (cur.generation == gen_ff);
      kind_ok    = (32'(kind_ff) < COMPONENT_KINDS);
      bit_mask   = kind_ok ? (COMPONENT_KINDS'(1) << kind_ff) : '0;
      hit        = (cur.components & bit_mask) != '0;
      next_gen   = cur.generation + GENERATION_BITS'(1);
      res_index  = index_ff;
      res_gen    = gen_ff;
      res_status = ST_OK;
      res_answer = 1'b0;
      slot_we    = 1'b0;
      slot_wa    = SLOT_BITS'(index_ff);
      slot_wd    = cur;
      free_we    = 1'b0;
      free_wd    = '{generation: next_gen, slot: SLOT_BITS'(index_ff)};
      free_count_in  = free_count_ff;
      fresh_count_in = fresh_count_ff;

      unique case (func_ff)
         FUNC_CREATE: begin
            if (free_count_ff != '0) begin
               // Reopen a recycled slot with its advanced generation
               slot_we       = 1'b1;
               slot_wa       = free_rd_ff.slot;
               slot_wd       = '{generation: free_rd_ff.generation, live: 1'b1,
                                 components: '0};
               res_index     = INDEX_BITS'(free_rd_ff.slot);
               res_gen       = free_rd_ff.generation;
               free_count_in = free_count_ff - COUNT_BITS'(1);
            end else if (32'(fresh_count_ff) < SLOT_COUNT) begin
               // Open the next never used slot at generation zero
               slot_we        = 1'b1;
               slot_wa        = fresh_count_ff[SLOT_BITS-1:0];
               slot_wd        = '{generation: '0, live: 1'b1, components: '0};
               res_index      = INDEX_BITS'(fresh_count_ff[SLOT_BITS-1:0]);
               res_gen        = '0;
               fresh_count_in = fresh_count_ff + COUNT_BITS'(1);
            end else begin
               res_status = ST_FULL;
            end
         end
         FUNC_DESTROY: begin
            if (!valid) begin
               res_status = ST_INVALID;
            end else begin
               slot_we = 1'b1;
               slot_wd = '{generation: next_gen, live: 1'b0, components: '0};
               if (32'(free_count_ff) < SLOT_COUNT) begin
                  free_we       = 1'b1;
                  free_count_in = free_count_ff + COUNT_BITS'(1);
               end
            end
         end
         FUNC_VALIDATE: begin
            res_answer = valid;
            res_status = valid ? ST_OK : ST_INVALID;
         end
         FUNC_ADD: begin
            if (!valid) begin
               res_status = ST_INVALID;
            end else if (!kind_ok) begin
               res_status = ST_LACKS;
            end else if (hit) begin
               res_status = ST_HAS;
            end else begin
               slot_we            = 1'b1;
               slot_wd.components = cur.components | bit_mask;
            end
         end
         FUNC_REMOVE: begin
            if (!valid) begin
               res_status = ST_INVALID;
            end else if (!hit) begin
               res_status = ST_LACKS;
            end else begin
               slot_we            = 1'b1;
               slot_wd.components = cur.components & ~bit_mask;
            end
         end
         FUNC_TEST: begin
            if (!valid) begin
               res_status = ST_INVALID;
            end else if (!hit) begin
               res_status = ST_LACKS;
            end else begin
               res_answer = 1'b1;
            end
         end
         default: begin
            res_status = ST_INVALID;
         end
      endcase

      // Hold all effects until the result register can take the item
      if (!finish) begin
         slot_we        = 1'b0;
         free_we        = 1'b0;
         free_count_in  = free_count_ff;
         fresh_count_in = fresh_count_ff;
      end
   end

   // Sequencer and result handshake
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         free_count_ff  <= '0;
         fresh_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_count_ff  <= free_count_in;
         fresh_count_ff <= fresh_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= {2'b00, res_answer, res_status, res_gen, res_index};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Recycled slots always come from slots that were handed out before
   a_free_below_fresh: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= fresh_count_ff)
      else $error("free stack deeper than slots ever handed out");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fresh_count_ff) <= SLOT_COUNT)
      else $error("fresh count beyond slot count");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted item did not enter evaluation");

   a_write_on_finish: assert property (@(posedge clock) disable iff (reset)
      (slot_we || free_we) |-> finish)
      else $error("memory written outside a finishing cycle");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished item left no result");

endmodule
